// ----- hw/rtl/indexed_doubly_linked_list_top_assert.svh -----
// Assertion macros for the indexed list block
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IDLL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("idll: implication check failed");
`define IDLL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("idll: next-cycle check failed");
`else
`define IDLL_ASSERT_IMPLIES(lbl, ante, cons)
`define IDLL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/idll_pkg.sv -----
package idll_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_BITS  = 4;
  localparam int LINK_BITS  = 5;

  localparam logic [LINK_BITS-1:0] NO_SLOT = 5'h1F;

  localparam logic [2:0] MODE_ADD_HEAD  = 3'd0;
  localparam logic [2:0] MODE_ADD_TAIL  = 3'd1;
  localparam logic [2:0] MODE_INS_AFTER = 3'd2;
  localparam logic [2:0] MODE_INS_BEFOR = 3'd3;
  localparam logic [2:0] MODE_DELETE    = 3'd4;
  localparam logic [2:0] MODE_GET_POS   = 3'd5;
  localparam logic [2:0] MODE_READ      = 3'd6;

  localparam logic [2:0] KIND_NOP  = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_DEL  = 3'd2;
  localparam logic [2:0] KIND_POS  = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADSLOT = 2'd2;
  localparam logic [1:0] ST_BADPOS  = 2'd3;

  localparam int IN_BITS  = 48;
  localparam int OUT_BITS = 64;

  typedef struct packed {
    logic [2:0]            kind;
    logic [2:0]            mode;
    logic [SLOT_BITS-1:0]  slot;
    logic [SLOT_BITS-1:0]  position;
    logic [VALUE_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [LINK_BITS-1:0] count;
    logic [LINK_BITS-1:0] cap;
    logic [LINK_BITS-1:0] head;
    logic [LINK_BITS-1:0] tail;
  } stat_t;

endpackage

// ----- hw/rtl/idll_front.sv -----
module idll_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [idll_pkg::IN_BITS-1:0]    in_tdata,
  output logic                            q_valid,
  input  logic                            q_ready,
  output idll_pkg::req_t                  q_data
);
  import idll_pkg::*;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  req_t       dec;
  logic       push, pop;

  always_comb begin
    dec.mode     = in_tdata[2:0];
    dec.slot     = in_tdata[6:3];
    dec.position = in_tdata[10:7];
    dec.payload  = in_tdata[42:11];
    unique case (in_tdata[2:0])
      MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_INS_AFTER, MODE_INS_BEFOR: dec.kind = KIND_ADD;
      MODE_DELETE:  dec.kind = KIND_DEL;
      MODE_GET_POS: dec.kind = KIND_POS;
      MODE_READ:    dec.kind = KIND_READ;
      default:      dec.kind = KIND_NOP;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign q_valid   = (fill_r != 2'd0);
  assign q_data    = q_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/idll_back.sv -----
module idll_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  idll_pkg::req_t                  q_data,
  input  logic                            cfg_valid,
  input  logic [4:0]                      cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [idll_pkg::OUT_BITS-1:0]   out_tdata,
  output idll_pkg::stat_t                 stat
);
  import idll_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_DEL   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_HOP   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [LINK_BITS-1:0]  nx_mem  [DEPTH];
  logic [LINK_BITS-1:0]  pv_mem  [DEPTH];
  logic [SLOT_BITS-1:0]  stk_mem [DEPTH];

  logic [VALUE_BITS-1:0] val_rd;
  logic [LINK_BITS-1:0]  nx_rd, pv_rd;
  logic [SLOT_BITS-1:0]  stk_rd;

  logic [SLOT_BITS-1:0]  val_ra, nx_ra, pv_ra, stk_ra;
  logic                  val_we, nx_we, pv_we, stk_we;
  logic [SLOT_BITS-1:0]  val_wa, nx_wa, pv_wa, stk_wa;
  logic [LINK_BITS-1:0]  nx_wd, pv_wd;

  logic [2:0]            state_r, state_nxt;
  req_t                  req_r, req_nxt;
  logic [4:0]            cap_r, cap_nxt, cnt_r, cnt_nxt;
  logic [4:0]            head_r, head_nxt, tail_r, tail_nxt;
  logic [DEPTH-1:0]      used_r, used_nxt, stkw_r, stkw_nxt;
  logic [SLOT_BITS-1:0]  sp_r, sp_nxt, n_r, n_nxt, cur_r, cur_nxt, idx_r, idx_nxt;
  logic                  bnx_r, bnx_nxt, bpv_r, bpv_nxt;
  logic [SLOT_BITS-1:0]  bnxa_r, bnxa_nxt, bpva_r, bpva_nxt;
  logic [1:0]            rst_r, rst_nxt;
  logic [4:0]            rs_r, rs_nxt, rn_r, rn_nxt, rp_r, rp_nxt;
  logic [VALUE_BITS-1:0] rv_r, rv_nxt;
  logic                  ov_r, ov_nxt;
  logic [OUT_BITS-1:0]   od_r, od_nxt;

  logic [SLOT_BITS-1:0]  sp_pop, sp_push, n_new;
  logic [4:0]            t_link, q_link, p_link;
  logic [4:0]            cap_w;

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= req_r.payload;
    val_rd <= val_mem[val_ra];
  end
  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd <= nx_mem[nx_ra];
  end
  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd <= pv_mem[pv_ra];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= req_r.slot;
    stk_rd <= stk_mem[stk_ra];
  end

  assign sp_pop  = 4'(cap_r - cnt_r - 5'd1);
  assign sp_push = 4'(cap_r - cnt_r);
  // never-pushed stack entries are not read; their reset order is computed instead
  assign n_new   = stkw_r[sp_r] ? stk_rd : 4'(cap_r - 5'd1 - {1'b0, sp_r});
  assign t_link  = (req_r.mode == MODE_INS_AFTER) ? nx_rd : pv_rd;
  assign q_link  = nx_rd;
  assign p_link  = pv_rd;
  assign cap_w   = (cfg_data == 5'd0) ? 5'd1 :
                   (cfg_data > 5'(DEPTH)) ? 5'(DEPTH) : cfg_data;

  assign q_ready    = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign stat.count = cnt_r;
  assign stat.cap   = cap_r;
  assign stat.head  = head_r;
  assign stat.tail  = tail_r;

  always_comb begin
    state_nxt = state_r; req_nxt = req_r;
    cap_nxt = cap_r; cnt_nxt = cnt_r; head_nxt = head_r; tail_nxt = tail_r;
    used_nxt = used_r; stkw_nxt = stkw_r;
    sp_nxt = sp_r; n_nxt = n_r; cur_nxt = cur_r; idx_nxt = idx_r;
    bnx_nxt = bnx_r; bpv_nxt = bpv_r; bnxa_nxt = bnxa_r; bpva_nxt = bpva_r;
    rst_nxt = rst_r; rs_nxt = rs_r; rn_nxt = rn_r; rp_nxt = rp_r; rv_nxt = rv_r;
    ov_nxt = ov_r; od_nxt = od_r;
    val_ra = cur_r; nx_ra = cur_r; pv_ra = cur_r; stk_ra = sp_pop;
    val_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; stk_we = 1'b0;
    val_wa = n_new; nx_wa = n_new; pv_wa = n_new; stk_wa = sp_push;
    nx_wd = NO_SLOT; pv_wd = NO_SLOT;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        nx_ra = q_data.slot;
        pv_ra = q_data.slot;
        if (q_valid) begin
          req_nxt = q_data;
          rst_nxt = ST_OK; rs_nxt = NO_SLOT; rn_nxt = NO_SLOT; rp_nxt = NO_SLOT;
          rv_nxt = '0;
          state_nxt = S_DONE;
          unique case (q_data.kind)
            KIND_ADD: begin
              if (cnt_r >= cap_r) rst_nxt = ST_FULL;
              else if (q_data.mode[1] && !used_r[q_data.slot]) rst_nxt = ST_BADSLOT;
              else begin
                sp_nxt = sp_pop;
                state_nxt = S_ALLOC;
              end
            end
            KIND_DEL: begin
              if (!used_r[q_data.slot]) rst_nxt = ST_BADSLOT;
              else state_nxt = S_DEL;
            end
            KIND_POS: begin
              if ({1'b0, q_data.position} >= cnt_r) rst_nxt = ST_BADPOS;
              else begin
                cur_nxt = head_r[3:0];
                idx_nxt = q_data.position;
                state_nxt = S_WALK;
              end
            end
            KIND_READ: begin
              if (!used_r[q_data.slot]) rst_nxt = ST_BADSLOT;
              else begin
                cur_nxt = q_data.slot;
                idx_nxt = '0;
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        n_nxt = n_new;
        val_we = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        used_nxt[n_new] = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        bnx_nxt = 1'b0; bpv_nxt = 1'b0;
        case (req_r.mode)
          MODE_ADD_HEAD: begin
            nx_wd = head_r; pv_wd = NO_SLOT;
            bpv_nxt = (head_r != NO_SLOT); bpva_nxt = head_r[3:0];
            head_nxt = {1'b0, n_new};
            if (tail_r == NO_SLOT) tail_nxt = {1'b0, n_new};
          end
          MODE_ADD_TAIL: begin
            nx_wd = NO_SLOT; pv_wd = tail_r;
            bnx_nxt = (tail_r != NO_SLOT); bnxa_nxt = tail_r[3:0];
            tail_nxt = {1'b0, n_new};
            if (head_r == NO_SLOT) head_nxt = {1'b0, n_new};
          end
          MODE_INS_AFTER: begin
            nx_wd = t_link; pv_wd = {1'b0, req_r.slot};
            bnx_nxt = 1'b1; bnxa_nxt = req_r.slot;
            bpv_nxt = (t_link != NO_SLOT); bpva_nxt = t_link[3:0];
            if (t_link == NO_SLOT) tail_nxt = {1'b0, n_new};
          end
          default: begin
            nx_wd = {1'b0, req_r.slot}; pv_wd = t_link;
            bpv_nxt = 1'b1; bpva_nxt = req_r.slot;
            bnx_nxt = (t_link != NO_SLOT); bnxa_nxt = t_link[3:0];
            if (t_link == NO_SLOT) head_nxt = {1'b0, n_new};
          end
        endcase
        rs_nxt = {1'b0, n_new};
        rn_nxt = nx_wd;
        rp_nxt = pv_wd;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        nx_we = bnx_r; nx_wa = bnxa_r; nx_wd = {1'b0, n_r};
        pv_we = bpv_r; pv_wa = bpva_r; pv_wd = {1'b0, n_r};
        state_nxt = S_DONE;
      end
      S_DEL: begin
        if (p_link != NO_SLOT) begin
          nx_we = 1'b1; nx_wa = p_link[3:0]; nx_wd = q_link;
        end else head_nxt = q_link;
        if (q_link != NO_SLOT) begin
          pv_we = 1'b1; pv_wa = q_link[3:0]; pv_wd = p_link;
        end else tail_nxt = p_link;
        used_nxt[req_r.slot] = 1'b0;
        stk_we = 1'b1;
        stkw_nxt[sp_push] = 1'b1;
        cnt_nxt = cnt_r - 5'd1;
        rs_nxt = {1'b0, req_r.slot};
        rn_nxt = q_link;
        rp_nxt = p_link;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        state_nxt = (idx_r == '0) ? S_RD : S_HOP;
      end
      S_HOP: begin
        cur_nxt = nx_rd[3:0];
        idx_nxt = idx_r - 4'd1;
        state_nxt = S_WALK;
      end
      S_RD: begin
        rs_nxt = {1'b0, cur_r};
        rv_nxt = val_rd;
        rn_nxt = nx_rd;
        rp_nxt = pv_rd;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {cnt_r, tail_r, head_r, rp_r, rn_r, rv_r, rs_r, rst_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a capacity write empties the list
    if (cfg_valid) begin
      cap_nxt = cap_w;
      cnt_nxt = '0;
      head_nxt = NO_SLOT;
      tail_nxt = NO_SLOT;
      used_nxt = '0;
      stkw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; sp_r <= sp_nxt; n_r <= n_nxt; cur_r <= cur_nxt; idx_r <= idx_nxt;
    bnxa_r <= bnxa_nxt; bpva_r <= bpva_nxt; bnx_r <= bnx_nxt; bpv_r <= bpv_nxt;
    rst_r <= rst_nxt; rs_r <= rs_nxt; rn_r <= rn_nxt; rp_r <= rp_nxt; rv_r <= rv_nxt;
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= 5'(DEPTH);
      cnt_r   <= '0;
      head_r  <= NO_SLOT;
      tail_r  <= NO_SLOT;
      used_r  <= '0;
      stkw_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      used_r  <= used_nxt;
      stkw_r  <= stkw_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ----- hw/rtl/indexed_doubly_linked_list_top.sv -----
// channel  dir  handshake                   data
// in       in   in_tvalid / in_tready       in_tdata   48b request word
// out      out  out_tvalid / out_tready     out_tdata  64b result word
// cfg      in   cfg_valid / cfg_ready       cfg_data   capacity
//
// Two-entry request queue in front; the back end runs one word at a time.
// Add/insert: alloc, link, done; delete: del, done; read: walk, rd, done; get
// position adds a registered next-link read per hop; full/bad requests: done.
// Result register lets a finished word wait while the queue keeps filling.
// rst_n is synchronous: empty list, capacity 16. A cfg write empties the list.
module indexed_doubly_linked_list_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[2:0] slot[6:3] position[10:7] payload[42:11], zero pad
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0] result_slot[6:2] slot_value[38:7] next_slot[43:39]
  // prev_slot[48:44] head_slot[53:49] tail_slot[58:54] list_size[63:59]
  output logic [63:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import idll_pkg::*;

  logic  q_valid, q_ready;
  req_t  q_data;
  stat_t stat;

  assign cfg_ready = 1'b1;

  idll_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_ready, .q_data
  );

  idll_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .cfg_valid, .cfg_data,
    .out_tvalid, .out_tready, .out_tdata, .stat
  );

`include "indexed_doubly_linked_list_top_assert.svh"

  `IDLL_ASSERT_IMPLIES(a_size_cap, 1'b1, stat.count <= stat.cap)
  `IDLL_ASSERT_IMPLIES(a_empty_head, stat.count == 5'd0, stat.head == NO_SLOT && stat.tail == NO_SLOT)
  `IDLL_ASSERT_IMPLIES(a_head_tail, stat.head == NO_SLOT, stat.tail == NO_SLOT)
  `IDLL_ASSERT_NEXT(a_cfg_clear, cfg_valid && cfg_ready, stat.count == 5'd0)

endmodule

// ----- dv/idll_checker.sv -----
module idll_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import idll_pkg::*;

  // highest field first, so status lands in the lowest bits of the word
  typedef struct packed {
    logic [LINK_BITS-1:0]  size;
    logic [LINK_BITS-1:0]  tl;
    logic [LINK_BITS-1:0]  hd;
    logic [LINK_BITS-1:0]  prv;
    logic [LINK_BITS-1:0]  nxt;
    logic [VALUE_BITS-1:0] value;
    logic [LINK_BITS-1:0]  rslot;
    logic [1:0]            status;
  } result_t;

  logic [VALUE_BITS-1:0] vals [DEPTH];
  logic [LINK_BITS-1:0]  nxt_l [DEPTH];
  logic [LINK_BITS-1:0]  prv_l [DEPTH];
  logic                  used [DEPTH];
  logic [SLOT_BITS-1:0]  free_q [DEPTH];
  int                    n_free, cap, cnt;
  logic [LINK_BITS-1:0]  hd, tl;
  result_t               expected_results [$];

  assign pending = expected_results.size();

  function automatic void clear_list(int c);
    for (int i = 0; i < DEPTH; i++) begin
      vals[i] = '0; nxt_l[i] = NO_SLOT; prv_l[i] = NO_SLOT; used[i] = 0;
    end
    cap = c;
    n_free = 0;
    for (int i = c; i > 0; i--) begin
      free_q[n_free] = SLOT_BITS'(i - 1);
      n_free++;
    end
    hd = NO_SLOT; tl = NO_SLOT; cnt = 0;
  endfunction

  function automatic result_t apply_request(logic [47:0] w);
    logic [2:0]            md;
    logic [SLOT_BITS-1:0]  s;
    logic [SLOT_BITS-1:0]  pos;
    logic [VALUE_BITS-1:0] pl;
    logic [LINK_BITS-1:0]  n, t, p, q, cur;
    result_t               r;
    md = w[2:0]; s = w[6:3]; pos = w[10:7]; pl = w[42:11];
    r = '0;
    r.status = ST_OK; r.rslot = NO_SLOT; r.nxt = NO_SLOT; r.prv = NO_SLOT;
    if (md <= MODE_INS_BEFOR) begin
      if (cnt >= cap || n_free == 0) r.status = ST_FULL;
      else if (md >= MODE_INS_AFTER && !used[s]) r.status = ST_BADSLOT;
      else begin
        n_free--;
        n = {1'b0, free_q[n_free]};
        vals[n] = pl;
        used[n] = 1;
        case (md)
          MODE_ADD_HEAD: begin
            prv_l[n] = NO_SLOT; nxt_l[n] = hd;
            if (hd != NO_SLOT) prv_l[hd] = n;
            hd = n;
            if (tl == NO_SLOT) tl = n;
          end
          MODE_ADD_TAIL: begin
            nxt_l[n] = NO_SLOT; prv_l[n] = tl;
            if (tl != NO_SLOT) nxt_l[tl] = n;
            tl = n;
            if (hd == NO_SLOT) hd = n;
          end
          MODE_INS_AFTER: begin
            t = nxt_l[s];
            prv_l[n] = {1'b0, s}; nxt_l[n] = t; nxt_l[s] = n;
            if (t != NO_SLOT) prv_l[t] = n;
            else tl = n;
          end
          default: begin
            t = prv_l[s];
            nxt_l[n] = {1'b0, s}; prv_l[n] = t; prv_l[s] = n;
            if (t != NO_SLOT) nxt_l[t] = n;
            else hd = n;
          end
        endcase
        cnt++;
        r.rslot = n; r.nxt = nxt_l[n]; r.prv = prv_l[n];
      end
    end else if (md == MODE_DELETE) begin
      if (!used[s]) r.status = ST_BADSLOT;
      else begin
        p = prv_l[s]; q = nxt_l[s];
        if (p != NO_SLOT) nxt_l[p] = q;
        else hd = q;
        if (q != NO_SLOT) prv_l[q] = p;
        else tl = p;
        used[s] = 0; nxt_l[s] = NO_SLOT; prv_l[s] = NO_SLOT;
        if (n_free < DEPTH) begin
          free_q[n_free] = s;
          n_free++;
        end
        if (cnt > 0) cnt--;
        r.rslot = {1'b0, s}; r.nxt = q; r.prv = p;
      end
    end else if (md == MODE_GET_POS) begin
      if (pos >= cnt) r.status = ST_BADPOS;
      else begin
        cur = hd;
        for (int i = 0; i < pos && cur != NO_SLOT; i++) cur = nxt_l[cur];
        if (cur == NO_SLOT) r.status = ST_BADPOS;
        else begin
          r.rslot = cur; r.value = vals[cur]; r.nxt = nxt_l[cur]; r.prv = prv_l[cur];
        end
      end
    end else if (md == MODE_READ) begin
      if (!used[s]) r.status = ST_BADSLOT;
      else begin
        r.rslot = {1'b0, s}; r.value = vals[s]; r.nxt = nxt_l[s]; r.prv = prv_l[s];
      end
    end
    r.hd = hd; r.tl = tl; r.size = LINK_BITS'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (!rst_n) begin
      clear_list(16);
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        clear_list(cfg_data == 0 ? 1 : (cfg_data > DEPTH ? DEPTH : int'(cfg_data)));
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: st %0d/%0d slot %0d/%0d val %h/%h nxt %0d/%0d",
                        " prv %0d/%0d hd %0d/%0d tl %0d/%0d sz %0d/%0d"},
                       want.status, got.status, want.rslot, got.rslot,
                       want.value, got.value, want.nxt, got.nxt,
                       want.prv, got.prv, want.hd, got.hd,
                       want.tl, got.tl, want.size, got.size);
          end
        end
      end
    end
  end
endmodule

// ----- dv/tb_indexed_doubly_linked_list_top.sv -----
module tb_indexed_doubly_linked_list_top;
  timeunit 1ns;
  timeprecision 1ps;
  import idll_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  int          fail_count, pending;
  int          send_idle, recv_stall;
  int          cur_cap = 16;

  always #2 clk = ~clk;

  indexed_doubly_linked_list_top i_dut (.*);

  idll_checker i_chk (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  // valid stays up after an accept; the next call either idles or drives a new word
  task automatic send_word(logic [2:0] md, logic [3:0] s, logic [3:0] pos,
                           logic [31:0] pl);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {5'b0, pl, pos, s, md};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    cur_cap = v == 0 ? 1 : (v > DEPTH ? DEPTH : v);
  endtask

  // mostly list-building traffic; slots biased toward the usable range
  task automatic random_words(int n);
    logic [2:0] md;
    int         r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      md = r < 22 ? MODE_ADD_HEAD : r < 40 ? MODE_ADD_TAIL : r < 52 ? MODE_INS_AFTER :
           r < 62 ? MODE_INS_BEFOR : r < 78 ? MODE_DELETE : r < 88 ? MODE_GET_POS :
           r < 97 ? MODE_READ : MODE_UNUSED;
      send_word(md, $urandom_range(3) == 0 ? 4'($urandom) : 4'($urandom_range(cur_cap - 1)),
                4'($urandom_range(cur_cap)), $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_word(MODE_GET_POS, 0, 0, 0);
    send_word(MODE_READ, 0, 0, 0);
    send_word(MODE_DELETE, 15, 0, 0);
    send_word(MODE_ADD_HEAD, 0, 0, 32'hFFFF_FFFF);
    send_word(MODE_ADD_TAIL, 0, 0, 32'h0);
    send_word(MODE_INS_AFTER, 0, 0, 32'hA5A5_5A5A);
    send_word(MODE_INS_BEFOR, 0, 0, 32'h5A5A_A5A5);
    send_word(MODE_INS_AFTER, 1, 0, 32'h1234_5678);
    send_word(MODE_INS_BEFOR, 15, 0, 32'h1);
    send_word(MODE_GET_POS, 0, 4, 0);
    send_word(MODE_GET_POS, 0, 5, 0);
    send_word(MODE_GET_POS, 0, 15, 0);
    send_word(MODE_READ, 2, 0, 0);
    send_word(MODE_UNUSED, 15, 15, 32'hFFFF_FFFF);
    send_word(MODE_DELETE, 0, 0, 0);
    send_word(MODE_DELETE, 0, 0, 0);
    write_capacity(5'd0);
    send_word(MODE_ADD_TAIL, 0, 0, 32'hDEAD_BEEF);
    send_word(MODE_ADD_HEAD, 0, 0, 32'h1);
    send_word(MODE_INS_AFTER, 0, 0, 32'h2);
    send_word(MODE_DELETE, 0, 0, 0);
    write_capacity(5'd31);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 65; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 65; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      if (ph == 2) write_capacity(5'd1);
      if (ph == 3) write_capacity(5'd16);
      if (ph == 5) write_capacity(5'(3 + $urandom_range(12)));
      if (ph == 6) write_capacity(5'd20);
      random_words(170);
      if (ph == 1) drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/idll_pkg.sv
hw/rtl/idll_front.sv
hw/rtl/idll_back.sv
hw/rtl/indexed_doubly_linked_list_top.sv
dv/idll_checker.sv
dv/tb_indexed_doubly_linked_list_top.sv
